@@ sv/rmsm_pkg.sv @@
// shared types and constants of the windowed rms current meter
`default_nettype none

package rmsm_pkg;

  // field widths
  localparam int unsigned GAIN_W = 24;
  localparam int unsigned OFFS_W = 24;
  localparam int unsigned WLEN_W = 16;
  localparam int unsigned RMS_W  = 24;
  localparam int unsigned WIN_W  = 16;
  localparam int unsigned SUM_W  = 64;
  localparam int unsigned DIV_W  = 17;
  localparam int unsigned CUR_W  = 34;
  localparam int unsigned ROOT_W = 32;

  // apb register map
  localparam int unsigned ADDR_W = 4;
  localparam int unsigned DATA_W = 32;
  localparam logic [1:0] REG_GAIN = 2'd0;
  localparam logic [1:0] REG_OFFS = 2'd1;
  localparam logic [1:0] REG_WLEN = 2'd2;

  // register reset values
  localparam logic [GAIN_W-1:0] GAIN_RST = 24'd28421;
  localparam logic [OFFS_W-1:0] OFFS_RST = 24'hFFFC71;  // -911
  localparam logic [WLEN_W-1:0] WLEN_RST = 16'd500;

  // back end sequencing
  localparam int unsigned STEP_W     = 6;
  localparam int unsigned DIV_STEPS  = 64;
  localparam int unsigned SQRT_STEPS = 32;

  typedef struct packed {
    logic [GAIN_W-1:0] gain;
    logic [OFFS_W-1:0] offset;
    logic [WLEN_W-1:0] wlen;
  } cal_cfg_t;

  // one closed window handed from front to back
  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [DIV_W-1:0] divisor;
    logic [WIN_W-1:0] win;
  } win_entry_t;

endpackage

`default_nettype wire

@@ sv/rmsm_front.sv @@
// front end: calibration, squaring, accumulation and window closing
`default_nettype none

module rmsm_front #(
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  rmsm_pkg::cal_cfg_t       cfg_i,
  input  wire                      in_valid_i,
  output logic                     in_ready_o,
  input  wire  [SAMPLE_BITS-1:0]   in_sample_i,
  output logic                     push_o,
  output rmsm_pkg::win_entry_t     push_data_o,
  input  wire                      full_i
);

  localparam int unsigned PROD_W = SAMPLE_BITS + rmsm_pkg::GAIN_W;
  localparam int unsigned CUR_W  = rmsm_pkg::CUR_W;
  localparam int unsigned SUM_W  = rmsm_pkg::SUM_W;
  localparam int unsigned OFFS_W = rmsm_pkg::OFFS_W;
  localparam int unsigned ROOT_W = rmsm_pkg::ROOT_W;
  localparam int unsigned WLEN_W = rmsm_pkg::WLEN_W;
  localparam int unsigned WIN_W  = rmsm_pkg::WIN_W;
  localparam int unsigned DIV_W  = rmsm_pkg::DIV_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_CAL,
    ST_SQR,
    ST_ACC
  } state_e;

  state_e                  state_q;
  logic [SAMPLE_BITS-1:0]  raw_q;
  logic [PROD_W-1:0]       prod_q;
  logic [CUR_W-1:0]        mag_q;
  logic [SUM_W-1:0]        sq_q;
  logic [SUM_W-1:0]        sum_q;
  logic [WLEN_W-1:0]       cnt_q;
  logic [WIN_W-1:0]        win_q;

  logic [CUR_W-1:0]        cur_w;
  logic [CUR_W-1:0]        mag_d;
  logic                    sq_big;
  logic [SUM_W-1:0]        sq_d;
  logic [SUM_W:0]          sum_ext;
  logic [SUM_W-1:0]        sum_d;
  logic [WLEN_W-1:0]       cnt_d;
  logic                    close;

  // current = (raw * gain) >> 8 + offset, in signed q.16
  assign cur_w = CUR_W'(prod_q[PROD_W-1:8])
               + {{(CUR_W-OFFS_W){cfg_i.offset[OFFS_W-1]}}, cfg_i.offset};
  assign mag_d = cur_w[CUR_W-1] ? (~cur_w + CUR_W'(1)) : cur_w;

  // a magnitude beyond 32 bits squares to all ones
  assign sq_big = |mag_q[CUR_W-1:ROOT_W];
  assign sq_d   = sq_big ? {SUM_W{1'b1}}
                         : SUM_W'(mag_q[ROOT_W-1:0]) * SUM_W'(mag_q[ROOT_W-1:0]);

  // saturating accumulate
  assign sum_ext = {1'b0, sum_q} + {1'b0, sq_q};
  assign sum_d   = sum_ext[SUM_W] ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];
  assign cnt_d   = cnt_q + WLEN_W'(1);

  // count wrapped to zero closes with a divisor of 65536
  assign close = (cnt_d == '0) || ((cfg_i.wlen != '0) && (cnt_d >= cfg_i.wlen));

  assign in_ready_o          = (state_q == ST_IDLE);
  assign push_o              = (state_q == ST_ACC) && !full_i && close;
  assign push_data_o.sum     = sum_d;
  assign push_data_o.divisor = (cnt_d == '0) ? {1'b1, {(DIV_W-1){1'b0}}}
                                             : {1'b0, cnt_d};
  assign push_data_o.win     = win_q + WIN_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      raw_q   <= '0;
      prod_q  <= '0;
      mag_q   <= '0;
      sq_q    <= '0;
      sum_q   <= '0;
      cnt_q   <= '0;
      win_q   <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            raw_q   <= in_sample_i;
            state_q <= ST_MUL;
          end
        end
        ST_MUL: begin
          prod_q  <= PROD_W'(raw_q) * PROD_W'(cfg_i.gain);
          state_q <= ST_CAL;
        end
        ST_CAL: begin
          mag_q   <= mag_d;
          state_q <= ST_SQR;
        end
        ST_SQR: begin
          sq_q    <= sq_d;
          state_q <= ST_ACC;
        end
        ST_ACC: begin
          if (!full_i) begin
            if (close) begin
              sum_q <= '0;
              cnt_q <= '0;
              win_q <= win_q + WIN_W'(1);
            end else begin
              sum_q <= sum_d;
              cnt_q <= cnt_d;
            end
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ sv/rmsm_fifo.sv @@
// two-entry queue of closed windows between front and back end
`default_nettype none

module rmsm_fifo (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   push_i,
  input  rmsm_pkg::win_entry_t  din_i,
  input  wire                   pop_i,
  output rmsm_pkg::win_entry_t  dout_o,
  output logic                  empty_o,
  output logic                  full_o
);

  rmsm_pkg::win_entry_t entry_q [2];
  logic                 wr_ptr_q;
  logic                 rd_ptr_q;
  logic [1:0]           count_q;

  assign dout_o  = entry_q[rd_ptr_q];
  assign empty_o = (count_q == 2'd0);
  assign full_o  = (count_q == 2'd2);

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) begin
      entry_q[wr_ptr_q] <= din_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i && !full_o) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i && !empty_o) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if ((push_i && !full_o) && !(pop_i && !empty_o)) begin
        count_q <= count_q + 2'd1;
      end else if (!(push_i && !full_o) && (pop_i && !empty_o)) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

@@ sv/rmsm_back.sv @@
// back end: bit-serial divide of the window sum, square root, result register
`default_nettype none

module rmsm_back (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  rmsm_pkg::win_entry_t                entry_i,
  input  wire                                 empty_i,
  output logic                                pop_o,
  output logic                                out_valid_o,
  input  wire                                 out_ready_i,
  output logic [rmsm_pkg::RMS_W-1:0]          out_rms_o,
  output logic [rmsm_pkg::WIN_W-1:0]          out_win_o
);

  localparam int unsigned SUM_W  = rmsm_pkg::SUM_W;
  localparam int unsigned DIV_W  = rmsm_pkg::DIV_W;
  localparam int unsigned ROOT_W = rmsm_pkg::ROOT_W;
  localparam int unsigned RMS_W  = rmsm_pkg::RMS_W;
  localparam int unsigned WIN_W  = rmsm_pkg::WIN_W;
  localparam int unsigned STEP_W = rmsm_pkg::STEP_W;
  localparam int unsigned SREM_W = ROOT_W + 2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_SQRT,
    ST_OUT
  } state_e;

  state_e               state_q;
  logic [SUM_W-1:0]     num_q;
  logic [DIV_W-1:0]     den_q;
  logic [DIV_W-1:0]     drem_q;
  logic [SREM_W-1:0]    srem_q;
  logic [ROOT_W-1:0]    root_q;
  logic [WIN_W-1:0]     win_q;
  logic [STEP_W-1:0]    step_q;
  logic                 out_valid_q;
  logic [RMS_W-1:0]     out_rms_q;
  logic [WIN_W-1:0]     out_win_q;

  logic [DIV_W:0]       dtrial;
  logic [DIV_W:0]       ddiff;
  logic                 dge;
  logic [SREM_W+1:0]    sshift;
  logic [SREM_W+1:0]    strial;
  logic [SREM_W+1:0]    sdiff;
  logic                 sge;
  logic                 out_free;

  // restoring divide, one quotient bit per cycle
  assign dtrial = {drem_q, num_q[SUM_W-1]};
  assign ddiff  = dtrial - {1'b0, den_q};
  assign dge    = (dtrial >= {1'b0, den_q});

  // digit-by-digit square root, two radicand bits per cycle
  assign sshift = {srem_q, num_q[SUM_W-1:SUM_W-2]};
  assign strial = (SREM_W+2)'({root_q, 2'b01});
  assign sdiff  = sshift - strial;
  assign sge    = (sshift >= strial);

  assign out_free    = !out_valid_q || out_ready_i;
  assign pop_o       = (state_q == ST_IDLE) && !empty_i;
  assign out_valid_o = out_valid_q;
  assign out_rms_o   = out_rms_q;
  assign out_win_o   = out_win_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      num_q       <= '0;
      den_q       <= '0;
      drem_q      <= '0;
      srem_q      <= '0;
      root_q      <= '0;
      win_q       <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
      out_rms_q   <= '0;
      out_win_q   <= '0;
    end else begin
      if ((state_q == ST_OUT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (!empty_i) begin
            num_q   <= entry_i.sum;
            den_q   <= entry_i.divisor;
            win_q   <= entry_i.win;
            drem_q  <= '0;
            step_q  <= '0;
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          drem_q <= dge ? ddiff[DIV_W-1:0] : dtrial[DIV_W-1:0];
          num_q  <= {num_q[SUM_W-2:0], dge};
          if (step_q == STEP_W'(rmsm_pkg::DIV_STEPS - 1)) begin
            srem_q  <= '0;
            root_q  <= '0;
            step_q  <= '0;
            state_q <= ST_SQRT;
          end else begin
            step_q <= step_q + STEP_W'(1);
          end
        end
        ST_SQRT: begin
          srem_q <= sge ? sdiff[SREM_W-1:0] : sshift[SREM_W-1:0];
          root_q <= {root_q[ROOT_W-2:0], sge};
          num_q  <= {num_q[SUM_W-3:0], 2'b00};
          step_q <= step_q + STEP_W'(1);
          if (step_q == STEP_W'(rmsm_pkg::SQRT_STEPS - 1)) begin
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            out_rms_q   <= (|root_q[ROOT_W-1:RMS_W]) ? {RMS_W{1'b1}}
                                                     : root_q[RMS_W-1:0];
            out_win_q   <= win_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ sv/windowed_rms_current_meter_top.sv @@
// top level of the windowed rms current meter: apb registers, front, queue, back
// flow: a sample beat passes the multiply, calibrate and square states and is folded
//   into the window sum in the accumulate state, which waits while the queue is full;
//   a window result takes a pop, 64 divide steps, 32 square root steps and a result load
// pacing: the front takes no new sample beat until the last one is folded in; the shared
//   divide / square root sequencer takes one window at a time; two closed windows queue
// reset: rst_ni async active low clears sum, count, window number and queue,
//   and loads the calibration registers with their defaults
`default_nettype none

module windowed_rms_current_meter_top #(
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  // sample stream in
  input  wire                                   s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  wire  [((SAMPLE_BITS+7)/8)*8-1:0]      s_axis_tdata,   // raw_sample
  // result stream out
  output logic                                  m_axis_tvalid,
  input  wire                                   m_axis_tready,
  output logic [39:0]                           m_axis_tdata,   // rms_current, window_number
  // apb register port
  input  wire                                   psel,
  input  wire                                   penable,
  input  wire                                   pwrite,
  input  wire  [rmsm_pkg::ADDR_W-1:0]           paddr,
  input  wire  [rmsm_pkg::DATA_W-1:0]           pwdata,
  output logic [rmsm_pkg::DATA_W-1:0]           prdata,
  output logic                                  pready
);

  localparam int unsigned GAIN_W = rmsm_pkg::GAIN_W;
  localparam int unsigned OFFS_W = rmsm_pkg::OFFS_W;
  localparam int unsigned WLEN_W = rmsm_pkg::WLEN_W;
  localparam int unsigned DATA_W = rmsm_pkg::DATA_W;

  rmsm_pkg::cal_cfg_t   cfg_q;
  rmsm_pkg::win_entry_t push_data;
  rmsm_pkg::win_entry_t pop_data;
  logic                 push;
  logic                 pop;
  logic                 fifo_empty;
  logic                 fifo_full;
  logic                 cfg_we;
  logic [rmsm_pkg::RMS_W-1:0] rms;
  logic [rmsm_pkg::WIN_W-1:0] win;

  // register file: zero wait state, written in the access phase
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain   <= rmsm_pkg::GAIN_RST;
      cfg_q.offset <= rmsm_pkg::OFFS_RST;
      cfg_q.wlen   <= rmsm_pkg::WLEN_RST;
    end else if (cfg_we) begin
      unique case (paddr[3:2])
        rmsm_pkg::REG_GAIN: cfg_q.gain   <= pwdata[GAIN_W-1:0];
        rmsm_pkg::REG_OFFS: cfg_q.offset <= pwdata[OFFS_W-1:0];
        rmsm_pkg::REG_WLEN: cfg_q.wlen   <= pwdata[WLEN_W-1:0];
        default: ;  // unmapped address, write dropped
      endcase
    end
  end

  // read back the raw register bits, zero extended
  always_comb begin
    unique case (paddr[3:2])
      rmsm_pkg::REG_GAIN: prdata = DATA_W'(cfg_q.gain);
      rmsm_pkg::REG_OFFS: prdata = DATA_W'(cfg_q.offset);
      rmsm_pkg::REG_WLEN: prdata = DATA_W'(cfg_q.wlen);
      default:            prdata = '0;
    endcase
  end

  // front: one sample at a time through multiply, calibrate, square, accumulate
  rmsm_front #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_sample_i (s_axis_tdata[SAMPLE_BITS-1:0]),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (fifo_full)
  );

  // closed windows wait here so the front keeps taking samples
  rmsm_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .din_i   (push_data),
    .pop_i   (pop),
    .dout_o  (pop_data),
    .empty_o (fifo_empty),
    .full_o  (fifo_full)
  );

  // back: sum / count, then square root, into the result register
  rmsm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .entry_i     (pop_data),
    .empty_i     (fifo_empty),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_rms_o   (rms),
    .out_win_o   (win)
  );

  // result beat: rms_current in the low 24 bits, window_number above
  assign m_axis_tdata = {win, rms};

endmodule

`default_nettype wire

@@ sv/rmsm_checker.sv @@
// port-level assertions for the windowed rms current meter, bound to the top level
`default_nettype none

module rmsm_checker (
  input wire                                clk_i,
  input wire                                rst_ni,
  input wire                                s_axis_tvalid,
  input wire                                s_axis_tready,
  input wire                                m_axis_tvalid,
  input wire                                m_axis_tready,
  input wire [39:0]                         m_axis_tdata,
  input wire                                psel,
  input wire                                penable,
  input wire                                pwrite,
  input wire [rmsm_pkg::ADDR_W-1:0]         paddr,
  input wire [rmsm_pkg::DATA_W-1:0]         pwdata,
  input wire [rmsm_pkg::DATA_W-1:0]         prdata,
  input wire                                pready
);

  logic [15:0] last_win_q;
  logic        out_beat;
  logic        in_beat;
  logic        wr_beat;

  assign out_beat = m_axis_tvalid && m_axis_tready;
  assign in_beat  = s_axis_tvalid && s_axis_tready;
  assign wr_beat  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_win_q <= '0;
    end else if (out_beat) begin
      last_win_q <= m_axis_tdata[39:24];
    end
  end

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat dropped or changed while stalled");

  // window numbers count up by one from beat to beat
  a_win_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_beat |-> m_axis_tdata[39:24] == last_win_q + 16'd1)
    else $error("window number skipped or repeated");

  // front is busy for the cycle after taking a sample
  a_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |=> !s_axis_tready)
    else $error("sample beat taken while front busy");

  // gain register reads back what was written
  a_gain_rb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_beat && paddr[3:2] == rmsm_pkg::REG_GAIN) ##1
    (psel && !pwrite && paddr[3:2] == rmsm_pkg::REG_GAIN)
    |-> prdata == {8'h00, $past(pwdata[23:0])})
    else $error("gain register readback mismatch");

  // window length register reads back what was written
  a_wlen_rb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_beat && paddr[3:2] == rmsm_pkg::REG_WLEN) ##1
    (psel && !pwrite && paddr[3:2] == rmsm_pkg::REG_WLEN)
    |-> prdata == {16'h0000, $past(pwdata[15:0])})
    else $error("window length register readback mismatch");

endmodule

bind windowed_rms_current_meter_top rmsm_checker u_rmsm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .psel          (psel),
  .penable       (penable),
  .pwrite        (pwrite),
  .paddr         (paddr),
  .pwdata        (pwdata),
  .prdata        (prdata),
  .pready        (pready)
);

`default_nettype wire
